>>> rtl/core/edp_pkg.sv
// Shared types, constants and arithmetic helpers for the encoder drive profile block.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package edp_pkg;

  // Default encoder count width.
  localparam int EDP_COUNT_BITS = 21;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WALL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CREEP_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BRAKE_MS       = 2'd2;

  localparam logic [10:0] WALL_THRESHOLD_RST = 11'd20;
  localparam logic [9:0]  CREEP_MARGIN_RST   = 10'd10;
  localparam logic [7:0]  BRAKE_MS_RST       = 8'd50;

  // Reported status codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_DONE = 3'd2;
  localparam logic [2:0] ST_WALL = 3'd3;
  localparam logic [2:0] ST_COLL = 3'd4;

  // Request command codes.
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [10:0] wall_threshold;
    logic [9:0]  creep_margin;
    logic [7:0]  brake_ms;
  } cfg_t;

  // Signed division by three, truncated toward zero, by reciprocal multiply.
  // 171/512 is exact for magnitudes up to 128.
  function automatic logic signed [7:0] edp_div3(input logic signed [7:0] p);
    logic [7:0]  m;
    logic [15:0] prod;
    logic [7:0]  q;
    m    = p[7] ? 8'(-p) : 8'(p);
    prod = 16'(m) * 16'd171;
    q    = 8'(prod >> 9);
    return p[7] ? $signed(8'(-q)) : $signed(q);
  endfunction

  // Signed division by ten, truncated toward zero; 205/2048 is exact here.
  function automatic logic signed [7:0] edp_div10(input logic signed [7:0] p);
    logic [7:0]  m;
    logic [15:0] prod;
    logic [7:0]  q;
    m    = p[7] ? 8'(-p) : 8'(p);
    prod = 16'(m) * 16'd205;
    q    = 8'(prod >> 11);
    return p[7] ? $signed(8'(-q)) : $signed(q);
  endfunction

  // Clamp a nine-bit signed motor value to the range -127 to 127.
  function automatic logic signed [7:0] edp_sat127(input logic signed [8:0] v);
    if (v > 9'sd127) begin
      return 8'sd127;
    end else if (v < -9'sd127) begin
      return -8'sd127;
    end
    return v[7:0];
  endfunction

endpackage

>>> rtl/core/edp_req_if.sv
// Request channel interface of the encoder drive profile block.
// Depends on edp_pkg for the default count width.
`timescale 1ns / 1ps

interface edp_req_if
  import edp_pkg::*;
#(
  parameter int COUNT_BITS = EDP_COUNT_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [7:0]            move_power;
  logic signed [COUNT_BITS-1:0] move_ticks;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  logic signed [11:0]           accel_x;
  logic                         collision_flag;

  modport source (
    output valid, cmd, move_power, move_ticks, left_count, right_count, accel_x,
           collision_flag,
    input  ready
  );
  modport sink (
    input  valid, cmd, move_power, move_ticks, left_count, right_count, accel_x,
           collision_flag,
    output ready
  );
endinterface

>>> rtl/core/edp_rsp_if.sv
// Result channel interface of the encoder drive profile block.
// Depends on edp_pkg for the default count width.
`timescale 1ns / 1ps

interface edp_rsp_if
  import edp_pkg::*;
#(
  parameter int COUNT_BITS = EDP_COUNT_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic signed [7:0]          left_power;
  logic signed [7:0]          right_power;
  logic [2:0]                 status;
  logic signed [COUNT_BITS:0] ticks_left;

  modport source (
    output valid, left_power, right_power, status, ticks_left,
    input  ready
  );
  modport sink (
    input  valid, left_power, right_power, status, ticks_left,
    output ready
  );
endinterface

>>> rtl/core/edp_cfg_regs.sv
// Configuration registers of the encoder drive profile block.
// Depends on edp_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module edp_cfg_regs
  import edp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WALL_THRESHOLD: cfg_nxt.wall_threshold = cfg_wdata[10:0];
        CFG_CREEP_MARGIN:   cfg_nxt.creep_margin   = cfg_wdata[9:0];
        CFG_BRAKE_MS:       cfg_nxt.brake_ms       = cfg_wdata[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wall_threshold <= WALL_THRESHOLD_RST;
      cfg_r.creep_margin   <= CREEP_MARGIN_RST;
      cfg_r.brake_ms       <= BRAKE_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/edp_in_stage.sv
// Input register of the encoder drive profile block.
// Depends on edp_pkg only for the default count width.
`timescale 1ns / 1ps

module edp_in_stage
  import edp_pkg::*;
#(
  parameter int COUNT_BITS = EDP_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic signed [7:0]            in_move_power,
  input  logic signed [COUNT_BITS-1:0] in_move_ticks,
  input  logic signed [COUNT_BITS-1:0] in_left_count,
  input  logic signed [COUNT_BITS-1:0] in_right_count,
  input  logic signed [11:0]           in_accel_x,
  input  logic                         in_collision_flag,
  input  logic                         take,
  output logic                         s1_valid,
  output logic                         s1_cmd,
  output logic signed [7:0]            s1_move_power,
  output logic signed [COUNT_BITS-1:0] s1_move_ticks,
  output logic signed [COUNT_BITS-1:0] s1_left_count,
  output logic signed [COUNT_BITS-1:0] s1_right_count,
  output logic signed [11:0]           s1_accel_x,
  output logic                         s1_collision_flag
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic                         accept;
  logic                         cmd_r;
  logic signed [7:0]            power_r;
  logic signed [COUNT_BITS-1:0] ticks_r;
  logic signed [COUNT_BITS-1:0] left_r;
  logic signed [COUNT_BITS-1:0] right_r;
  logic signed [11:0]           accel_r;
  logic                         coll_r;

  // The register frees up in the same cycle the core takes its request.
  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      power_r <= in_move_power;
      ticks_r <= in_move_ticks;
      left_r  <= in_left_count;
      right_r <= in_right_count;
      accel_r <= in_accel_x;
      coll_r  <= in_collision_flag;
    end
  end

  assign s1_valid          = valid_r;
  assign s1_cmd            = cmd_r;
  assign s1_move_power     = power_r;
  assign s1_move_ticks     = ticks_r;
  assign s1_left_count     = left_r;
  assign s1_right_count    = right_r;
  assign s1_accel_x        = accel_r;
  assign s1_collision_flag = coll_r;

endmodule

>>> rtl/core/edp_core.sv
// Move sequencer and result register of the encoder drive profile block.
// Depends on edp_pkg for status codes, cfg_t and the divide and clamp helpers.
`timescale 1ns / 1ps

module edp_core
  import edp_pkg::*;
#(
  parameter int COUNT_BITS = EDP_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  logic                         s1_valid,
  input  logic                         s1_cmd,
  input  logic signed [7:0]            s1_move_power,
  input  logic signed [COUNT_BITS-1:0] s1_move_ticks,
  input  logic signed [COUNT_BITS-1:0] s1_left_count,
  input  logic signed [COUNT_BITS-1:0] s1_right_count,
  input  logic signed [11:0]           s1_accel_x,
  input  logic                         s1_collision_flag,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [7:0]            out_left_power,
  output logic signed [7:0]            out_right_power,
  output logic [2:0]                   out_status,
  output logic signed [COUNT_BITS:0]   out_ticks_left
);

  localparam int CW = COUNT_BITS;
  localparam int TW = COUNT_BITS + 1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FULL, PH_SLOW, PH_BRAKE, PH_DONE, PH_WALL, PH_COLL
  } phase_t;

  phase_t ph_r, ph_nxt;
  logic signed [7:0]    q3_r, q3_nxt;      // power / 3
  logic signed [7:0]    q10_r, q10_nxt;    // power / 10
  logic signed [7:0]    brk_r, brk_nxt;    // -(power / 2)
  logic signed [7:0]    pwr_r, pwr_nxt;
  logic signed [CW-1:0] tgt_r, tgt_nxt;
  logic [7:0]           bc_r, bc_nxt;
  logic signed [TW-1:0] hl_r, hl_nxt;
  logic                 ov_r, ov_nxt;
  logic signed [7:0]    lp_r, lp_nxt;
  logic signed [7:0]    rp_r, rp_nxt;
  logic [2:0]           st_r, st_nxt;
  logic signed [TW-1:0] tl_r, tl_nxt;

  logic [CW-1:0]        al, ar, at;
  logic [CW+3:0]        al10, at9;
  logic [CW:0]          al_m;
  logic [11:0]          aa;
  logic signed [7:0]    rmod, dl;
  logic                 full_go, slow_chk, slow_go, enter_brake, driving, braking;
  logic                 wall_hit;
  logic [7:0]           bc_cur, bc_dec;

  assign take = s1_valid && (!ov_r || out_ready);

  // Magnitudes; the most negative count wraps to its correct unsigned value.
  assign al = s1_left_count[CW-1]  ? CW'(-s1_left_count)  : CW'(s1_left_count);
  assign ar = s1_right_count[CW-1] ? CW'(-s1_right_count) : CW'(s1_right_count);
  assign at = tgt_r[CW-1]          ? CW'(-tgt_r)          : CW'(tgt_r);
  assign aa = s1_accel_x[11]       ? 12'(-s1_accel_x)     : 12'(s1_accel_x);

  assign al10 = ({4'b0, al} << 3) + ({4'b0, al} << 1);
  assign at9  = ({4'b0, at} << 3) + {4'b0, at};
  assign al_m = {1'b0, al} + (CW+1)'(cfg.creep_margin);

  assign full_go     = (ph_r == PH_FULL) && (al10 < at9);
  assign slow_chk    = ((ph_r == PH_FULL) && !full_go) || (ph_r == PH_SLOW);
  assign slow_go     = slow_chk && (al_m < {1'b0, at});
  assign enter_brake = slow_chk && !slow_go;
  assign driving     = full_go || slow_go;
  assign braking     = enter_brake || (ph_r == PH_BRAKE);
  assign bc_cur      = enter_brake ? cfg.brake_ms : bc_r;
  assign bc_dec      = bc_cur - 8'd1;
  assign wall_hit    = aa > {1'b0, cfg.wall_threshold};

  always_comb begin
    if (al > ar) begin
      rmod = q10_r;
    end else if (al < ar) begin
      rmod = -q10_r;
    end else begin
      rmod = 8'sd0;
    end
    dl = full_go ? pwr_r : q3_r;
  end

  always_comb begin
    ph_nxt  = ph_r;
    pwr_nxt = pwr_r;
    q3_nxt  = q3_r;
    q10_nxt = q10_r;
    brk_nxt = brk_r;
    tgt_nxt = tgt_r;
    bc_nxt  = bc_r;
    hl_nxt  = hl_r;
    lp_nxt  = lp_r;
    rp_nxt  = rp_r;
    st_nxt  = st_r;
    tl_nxt  = tl_r;
    ov_nxt  = ov_r && !out_ready;
    if (take) begin
      ov_nxt = 1'b1;
      lp_nxt = 8'sd0;
      rp_nxt = 8'sd0;
      tl_nxt = '0;
      if (s1_cmd == CMD_START) begin
        pwr_nxt = s1_move_power;
        q3_nxt  = edp_div3(s1_move_power);
        q10_nxt = edp_div10(s1_move_power);
        brk_nxt = -(s1_move_power >>> 1)
                  - $signed({7'b0, s1_move_power[7] & s1_move_power[0]});
        tgt_nxt = s1_move_ticks;
        hl_nxt  = '0;
        ph_nxt  = PH_FULL;
      end else if (driving) begin
        if (wall_hit) begin
          ph_nxt = PH_WALL;
        end else if (s1_collision_flag) begin
          ph_nxt = PH_COLL;
          hl_nxt = {tgt_r[CW-1], tgt_r} - {s1_left_count[CW-1], s1_left_count};
        end else begin
          ph_nxt = full_go ? PH_FULL : PH_SLOW;
          lp_nxt = edp_sat127({dl[7], dl});
          rp_nxt = edp_sat127({dl[7], dl} + {rmod[7], rmod});
        end
      end else if (braking) begin
        if (bc_cur == 8'd0) begin
          ph_nxt = PH_DONE;
        end else if (s1_collision_flag) begin
          ph_nxt = PH_COLL;
          hl_nxt = -$signed({{(TW-8){1'b0}}, bc_cur});
        end else begin
          ph_nxt = PH_BRAKE;
          bc_nxt = bc_dec;
          lp_nxt = brk_r;
          rp_nxt = brk_r;
          tl_nxt = -$signed({{(TW-8){1'b0}}, bc_dec});
        end
      end
      case (ph_nxt)
        PH_FULL, PH_SLOW, PH_BRAKE: st_nxt = ST_RUN;
        PH_DONE:                    st_nxt = ST_DONE;
        PH_WALL:                    st_nxt = ST_WALL;
        PH_COLL: begin
          st_nxt = ST_COLL;
          tl_nxt = hl_nxt;
        end
        default:                    st_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
    end
    pwr_r <= pwr_nxt;
    q3_r  <= q3_nxt;
    q10_r <= q10_nxt;
    brk_r <= brk_nxt;
    tgt_r <= tgt_nxt;
    bc_r  <= bc_nxt;
    hl_r  <= hl_nxt;
    lp_r  <= lp_nxt;
    rp_r  <= rp_nxt;
    st_r  <= st_nxt;
    tl_r  <= tl_nxt;
  end

  assign out_valid       = ov_r;
  assign out_left_power  = lp_r;
  assign out_right_power = rp_r;
  assign out_status      = st_r;
  assign out_ticks_left  = tl_r;

  // A start always answers running with both motors off.
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_cmd == CMD_START) |=>
      (st_r == ST_RUN && lp_r == 8'sd0 && rp_r == 8'sd0 && tl_r == '0))
    else $error("start request did not produce a clean running result");

  // Samples before any start report idle.
  a_idle_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_cmd == CMD_SAMPLE && ph_r == PH_IDLE) |=> (st_r == ST_IDLE))
    else $error("sample in idle reported a non-idle status");

  // A wall abort stops both motors and reports no remaining ticks.
  a_wall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r == ST_WALL) |-> (lp_r == 8'sd0 && rp_r == 8'sd0 && tl_r == '0))
    else $error("wall abort result drives the motors");

  // A braking countdown applies the same command to both sides.
  a_brake_even: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r == ST_RUN && tl_r != '0) |-> (lp_r == rp_r))
    else $error("braking sample drives the sides unevenly");

endmodule

>>> rtl/core/encoder_drive_profile_top.sv
// Top level of the encoder drive profile block: configuration registers,
// input register and move sequencer. Depends on edp_pkg, edp_req_if and edp_rsp_if.
`timescale 1ns / 1ps

// The block sequences one straight drive move from one-millisecond sensor
// requests. A start request (cmd 0) latches the drive power and the target
// tick count; each sample request (cmd 1) returns one result with the left and
// right motor commands, the move status and the remaining tick or brake
// count. The move runs at full power until the left encoder reaches nine
// tenths of the target, then at a third of the power until it is within the
// creep margin, then brakes at minus half the power for brake_ms samples.
// The right side is trimmed by a tenth of the power toward the slower wheel.
// A wall hit on the accelerometer while driving, or the external collision
// flag while driving or braking, aborts the move. Every request yields exactly
// one result. The block accepts a request in every clock cycle as long as
// results are taken. An accepted request waits in the input register until
// the sequencer takes it and writes its result into the result register,
// which raises out_chan.valid. That step waits only while the result
// register still holds an untaken result. A result waiting on a stalled
// output does not block the next request from entering the input register.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while no request is in flight, as the block does not
// enforce this. Writes to an index outside the three registers are ignored.
module encoder_drive_profile_top
  import edp_pkg::*;
#(
  parameter int COUNT_BITS = EDP_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  edp_req_if.sink                  in_chan,
  edp_rsp_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t cfg;

  logic                         take;
  logic                         s1_valid;
  logic                         s1_cmd;
  logic signed [7:0]            s1_move_power;
  logic signed [COUNT_BITS-1:0] s1_move_ticks;
  logic signed [COUNT_BITS-1:0] s1_left_count;
  logic signed [COUNT_BITS-1:0] s1_right_count;
  logic signed [11:0]           s1_accel_x;
  logic                         s1_collision_flag;

  // Register values take effect for the next request the sequencer handles.
  edp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The input register holds one request until the sequencer takes it.
  edp_in_stage #(
    .COUNT_BITS (COUNT_BITS)
  ) u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_cmd            (in_chan.cmd),
    .in_move_power     (in_chan.move_power),
    .in_move_ticks     (in_chan.move_ticks),
    .in_left_count     (in_chan.left_count),
    .in_right_count    (in_chan.right_count),
    .in_accel_x        (in_chan.accel_x),
    .in_collision_flag (in_chan.collision_flag),
    .take              (take),
    .s1_valid          (s1_valid),
    .s1_cmd            (s1_cmd),
    .s1_move_power     (s1_move_power),
    .s1_move_ticks     (s1_move_ticks),
    .s1_left_count     (s1_left_count),
    .s1_right_count    (s1_right_count),
    .s1_accel_x        (s1_accel_x),
    .s1_collision_flag (s1_collision_flag)
  );

  // The sequencer updates the move state and loads the result register
  // whenever a request waits and that register is empty or its result is taken.
  edp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .s1_valid          (s1_valid),
    .s1_cmd            (s1_cmd),
    .s1_move_power     (s1_move_power),
    .s1_move_ticks     (s1_move_ticks),
    .s1_left_count     (s1_left_count),
    .s1_right_count    (s1_right_count),
    .s1_accel_x        (s1_accel_x),
    .s1_collision_flag (s1_collision_flag),
    .take              (take),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_left_power    (out_chan.left_power),
    .out_right_power   (out_chan.right_power),
    .out_status        (out_chan.status),
    .out_ticks_left    (out_chan.ticks_left)
  );

endmodule
